>>> hw/rtl/eso_hsc_pkg.sv
package eso_hsc_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_KP    = 3'd0;
  localparam logic [2:0] REG_B0    = 3'd1;
  localparam logic [2:0] REG_W     = 3'd2;
  localparam logic [2:0] REG_DZ    = 3'd3;
  localparam logic [2:0] REG_LIM   = 3'd4;
  localparam logic [2:0] REG_SAFE  = 3'd5;

  localparam logic [30:0] KP_RST   = 31'd0;
  localparam logic [30:0] B0_RST   = 31'd2293760;
  localparam logic [30:0] W_RST    = 31'd65536;
  localparam logic [30:0] DZ_RST   = 31'd1638400;
  localparam logic [30:0] LIM_RST  = 31'h7FFFFFFF;

  localparam logic [5:0] MUL_STEPS = 6'd32;
  localparam logic [5:0] DIV_STEPS = 6'd49;

  localparam logic [48:0] NUM_BETA0 = 49'h1_0000_0000;
  localparam logic [48:0] NUM_BETA1 = 49'h1_0000_0000_0000;
  localparam logic [32:0] QONE      = 33'sd65536;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV0, ST_TT, ST_DIV1, ST_M1, ST_MBW, ST_M2, ST_M3, ST_MHB,
    ST_M4, ST_MLW, ST_MZL, ST_MU, ST_DCOMP, ST_MHW, ST_FIN
  } state_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    hi = 65'sh0_7FFF_FFFF;
    lo = -65'sh0_8000_0000;
    if (x > hi) return 32'sh7FFF_FFFF;
    else if (x < lo) return 32'sh8000_0000;
    else return x[31:0];
  endfunction

  function automatic logic signed [64:0] ext32(input logic signed [31:0] x);
    return {{33{x[31]}}, x};
  endfunction

  // Dead zone: x-d above d, x+d below -d, zero between
  function automatic logic signed [31:0] deadz(input logic signed [32:0] x,
                                               input logic [30:0] d);
    logic signed [64:0] xx;
    logic signed [64:0] dd;
    xx = {{32{x[32]}}, x};
    dd = {34'd0, d};
    if (xx > dd) return sat32(xx - dd);
    else if (xx < -dd) return sat32(xx + dd);
    else return 32'sd0;
  endfunction

endpackage

>>> hw/rtl/eso_height_speed_controller.sv
// Each item runs through up to 11 serial products and 3 serial quotients (load, 32 or 49 steps,
// capture) and then the finish state that presents the output; the third quotient is skipped
// when no new compensation is computed, and it and the last product when compensation is off.
// The block takes one item at a time; a result stalled in the output register holds the next
// item in its finish state. Reset (rst_n, synchronous, active low) clears observer
// state, held compensation and handshakes, and loads register defaults.
module eso_height_speed_controller (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // target, measured, drive_in, time_step
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // drive_out, est_value, est_disturbance
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import eso_hsc_pkg::*;

  state_t state_r, state_nxt;

  logic [30:0] kp_r, b0_r, w_r, dz_r, lim_r;
  logic        safe_r;

  logic signed [31:0] z0_r, z1_r, held_r;
  logic signed [31:0] target_r, drive_r, e_r, s_r, tmp_r, u_r;
  logic [15:0]        t_r;
  logic [30:0]        beta0_r, beta1_r;
  logic [36:0]        den1_r;

  // Serial unit registers
  logic        run_r;
  logic [5:0]  cnt_r;
  logic [63:0] mcand_r, acc_r;
  logic [31:0] mplier_r;
  logic        neg_r;
  logic [48:0] quo_r;
  logic [37:0] rem_r;
  logic [36:0] den_r;

  logic signed [32:0] op_a, op_b, a_abs, b_abs;
  logic [48:0]        div_num;
  logic [36:0]        div_den;
  logic               is_div, done;
  logic [5:0]         steps;
  logic signed [64:0] prod;
  logic signed [31:0] mul_res;
  logic [37:0]        rem_sh;
  logic               rem_ge;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  logic               out_tvalid_r;
  logic [95:0]        out_tdata_r;
  logic signed [32:0] e_abs;
  logic signed [64:0] comp_val;
  logic signed [32:0] b0_q;
  logic signed [31:0] u_cl;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Register read back
  always_comb begin
    unique case (cfg_idx)
      REG_KP:   cfg_prdata = {1'b0, kp_r};
      REG_B0:   cfg_prdata = {1'b0, b0_r};
      REG_W:    cfg_prdata = {1'b0, w_r};
      REG_DZ:   cfg_prdata = {1'b0, dz_r};
      REG_LIM:  cfg_prdata = {1'b0, lim_r};
      REG_SAFE: cfg_prdata = {31'd0, safe_r};
      default:  cfg_prdata = 32'd0;
    endcase
  end

  assign is_div = (state_r == ST_DIV0) || (state_r == ST_DIV1) || (state_r == ST_DCOMP);
  assign steps  = is_div ? DIV_STEPS : MUL_STEPS;
  assign done   = run_r && (cnt_r == steps);

  // Product and quotient step logic
  assign prod    = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
  assign mul_res = sat32(prod >>> 16);
  assign rem_sh  = {rem_r[36:0], quo_r[48]};
  assign rem_ge  = rem_sh >= {1'b0, den_r};
  assign a_abs   = op_a[32] ? -op_a : op_a;
  assign b_abs   = op_b[32] ? -op_b : op_b;
  assign e_abs   = e_r[31] ? -{e_r[31], e_r} : {e_r[31], e_r};
  assign comp_val = z1_r[31] ? -$signed({16'd0, quo_r}) : $signed({16'd0, quo_r});
  // b0 + 1.0 is always positive, so the sign bit stays clear
  assign b0_q    = {1'b0, sat32({34'd0, b0_r} + {{32{1'b0}}, QONE})};
  assign u_cl    = (u_r > $signed({1'b0, lim_r})) ? $signed({1'b0, lim_r}) :
                   (u_r < -$signed({1'b0, lim_r})) ? -$signed({1'b0, lim_r}) : u_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_DIV0;
      ST_DIV0:  if (done) state_nxt = ST_TT;
      ST_TT:    if (done) state_nxt = ST_DIV1;
      ST_DIV1:  if (done) state_nxt = ST_M1;
      ST_M1:    if (done) state_nxt = ST_MBW;
      ST_MBW:   if (done) state_nxt = ST_M2;
      ST_M2:    if (done) state_nxt = ST_M3;
      ST_M3:    if (done) state_nxt = ST_MHB;
      ST_MHB:   if (done) state_nxt = ST_M4;
      ST_M4:    if (done) state_nxt = ST_MLW;
      ST_MLW:   if (done) state_nxt = ST_MZL;
      ST_MZL:   if (done) state_nxt = ST_MU;
      ST_MU: begin
        if (done) begin
          if (b0_r == 31'd0 || safe_r) state_nxt = ST_FIN;
          else if (e_abs > $signed({2'b0, dz_r})) state_nxt = ST_DCOMP;
          else state_nxt = ST_MHW;
        end
      end
      ST_DCOMP: if (done) state_nxt = ST_MHW;
      ST_MHW:   if (done) state_nxt = ST_FIN;
      ST_FIN:   if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Operand selection and handshake outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    op_a      = 33'sd0;
    op_b      = 33'sd0;
    div_num   = 49'd0;
    div_den   = 37'd1;
    unique case (state_r)
      ST_DIV0:  begin div_num = NUM_BETA0; div_den = {21'd0, t_r}; end
      ST_TT:    begin op_a = {17'd0, t_r}; op_b = {17'd0, t_r}; end
      ST_DIV1:  begin div_num = NUM_BETA1; div_den = den1_r; end
      ST_M1:    begin op_a = {2'b0, beta0_r}; op_b = {e_r[31], e_r}; end
      ST_MBW:   begin op_a = {2'b0, b0_r}; op_b = {2'b0, w_r}; end
      ST_M2:    begin op_a = {tmp_r[31], tmp_r}; op_b = {drive_r[31], drive_r}; end
      ST_M3:    begin op_a = {17'd0, t_r}; op_b = {s_r[31], s_r}; end
      ST_MHB:   begin op_a = {17'd0, t_r}; op_b = {2'b0, beta1_r}; end
      ST_M4:    begin op_a = {tmp_r[31], tmp_r}; op_b = {e_r[31], e_r}; end
      ST_MLW:   begin op_a = {2'b0, lim_r}; op_b = {2'b0, w_r}; end
      ST_MZL:   begin op_a = {tmp_r[31], tmp_r}; op_b = b0_q; end
      ST_MU:    begin op_a = {2'b0, kp_r}; op_b = {e_r[31], e_r}; end
      ST_DCOMP: begin
        div_num = {1'b0, (z1_r[31] ? 32'(-z1_r) : 32'(z1_r)), 16'd0};
        div_den = {6'd0, b0_r};
      end
      ST_MHW:   begin op_a = {2'b0, w_r}; op_b = {held_r[31], held_r}; end
      default:  begin end
    endcase
  end

  // Control state, configuration and observer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      run_r        <= 1'b0;
      cnt_r        <= 6'd0;
      out_tvalid_r <= 1'b0;
      kp_r         <= KP_RST;
      b0_r         <= B0_RST;
      w_r          <= W_RST;
      dz_r         <= DZ_RST;
      lim_r        <= LIM_RST;
      safe_r       <= 1'b0;
      z0_r         <= 32'sd0;
      z1_r         <= 32'sd0;
      held_r       <= 32'sd0;
    end else begin
      state_r <= state_nxt;

      // Present the item from the finish state, drop it once taken
      if (state_r == ST_FIN && (!out_tvalid_r || out_tready)) out_tvalid_r <= 1'b1;
      else if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;

      // Register writes
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_KP:   kp_r   <= cfg_pwdata[30:0];
          REG_B0:   b0_r   <= cfg_pwdata[30:0];
          REG_W:    w_r    <= cfg_pwdata[30:0];
          REG_DZ:   dz_r   <= cfg_pwdata[30:0];
          REG_LIM:  lim_r  <= cfg_pwdata[30:0];
          REG_SAFE: safe_r <= cfg_pwdata[0];
          default:  begin end
        endcase
      end

      // Start, step and finish the serial unit
      if (state_r != ST_IDLE && state_r != ST_FIN) begin
        if (!run_r) begin
          run_r <= 1'b1;
          cnt_r <= 6'd0;
        end else if (done) begin
          run_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 6'd1;
        end
      end

      // Capture results into the observer state
      if (done) begin
        unique case (state_r)
          ST_M3: z0_r <= sat32(ext32(z0_r) + ext32(mul_res));
          ST_M4: z1_r <= sat32(ext32(z1_r) - ext32(mul_res));
          ST_MZL: begin
            if (safe_r) z1_r <= 32'sd0;
            else if (z1_r > mul_res) z1_r <= mul_res;
            else if (z1_r < -mul_res) z1_r <= -mul_res;
          end
          ST_DCOMP: held_r <= sat32(comp_val);
          default: begin end
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // Latch the item and form the observer error
    if (state_r == ST_IDLE && in_tvalid) begin
      target_r <= in_tdata[31:0];
      drive_r  <= in_tdata[95:64];
      t_r      <= (in_tdata[111:96] == 16'd0) ? 16'd1 : in_tdata[111:96];
      e_r      <= deadz({z0_r[31], z0_r} - {in_tdata[63], in_tdata[63:32]}, dz_r);
    end

    if (state_r != ST_IDLE && state_r != ST_FIN) begin
      if (!run_r) begin
        // Load operands as magnitudes
        mcand_r  <= {32'd0, a_abs[31:0]};
        mplier_r <= b_abs[31:0];
        acc_r    <= 64'd0;
        neg_r    <= op_a[32] ^ op_b[32];
        quo_r    <= div_num;
        rem_r    <= 38'd0;
        den_r    <= div_den;
      end else if (!done) begin
        // One multiplier bit and one quotient bit per cycle
        if (mplier_r[0]) acc_r <= acc_r + mcand_r;
        mcand_r  <= {mcand_r[62:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[31:1]};
        rem_r    <= rem_ge ? rem_sh - {1'b0, den_r} : rem_sh;
        quo_r    <= {quo_r[47:0], rem_ge};
      end
    end

    if (done) begin
      unique case (state_r)
        ST_DIV0: beta0_r <= (quo_r > 49'h7FFF_FFFF) ? 31'h7FFF_FFFF : quo_r[30:0];
        ST_TT:   den1_r  <= {acc_r[31:0], 5'd0} - {4'd0, acc_r[31:0], 1'b0};
        ST_DIV1: beta1_r <= (quo_r > 49'h7FFF_FFFF) ? 31'h7FFF_FFFF : quo_r[30:0];
        ST_M1:   s_r     <= sat32(ext32(z1_r) - ext32(mul_res));
        ST_MBW:  tmp_r   <= mul_res;
        ST_M2:   s_r     <= sat32(ext32(s_r) + ext32(mul_res));
        ST_MHB:  tmp_r   <= mul_res;
        ST_MLW:  tmp_r   <= mul_res;
        // Tracking error from the fresh estimate
        ST_MZL:  e_r     <= deadz({target_r[31], target_r} - {z0_r[31], z0_r}, dz_r);
        ST_MU:   u_r     <= mul_res;
        ST_MHW:  u_r     <= sat32(ext32(u_r) - ext32(mul_res));
        default: begin end
      endcase
    end

    if (state_r == ST_FIN && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= {z1_r, z0_r, u_cl};
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import eso_hsc_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 6000000;
  localparam int DRAIN_CYCLES = 700;

  typedef struct {
    int drive;
    int est;
    int disturb;
  } ctrl_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;   // target, measured, drive_in, time_step
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;  // drive_out, est_value, est_disturbance
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  // Controller copy: registers and observer state
  longint kp, b0, wt, band, lim;
  bit     safe;
  int     z0, z1, hold_comp;

  ctrl_result_t expected_results[$];
  bit           failed;
  bit           calm;
  int unsigned  cycles;
  int           stall_left;

  eso_height_speed_controller u_top (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int sat(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return int'(x);
  endfunction

  // Product in Q16.16, rounded toward minus infinity
  function automatic int qm(longint a, longint b);
    longint p;
    p = a * b;
    return sat(p >>> 16);
  endfunction

  function automatic int dead_zone(longint x, longint d);
    if (x > d) return sat(x - d);
    if (x < -d) return sat(x + d);
    return 0;
  endfunction

  // Advance the observer by one sample and work out the control output
  function automatic ctrl_result_t control_step(int tg, int ms, int dr, logic [15:0] ts);
    ctrl_result_t r;
    longint t, beta0, beta1, zl, u;
    int e, s, hb, e1, comp;
    t = (ts == 16'd0) ? 64'sd1 : longint'(ts);
    beta0 = (64'sd1 <<< 32) / t;
    if (beta0 > 64'sd2147483647) beta0 = 64'sd2147483647;
    beta1 = (64'sd1 <<< 48) / (30 * t * t);
    if (beta1 > 64'sd2147483647) beta1 = 64'sd2147483647;
    e = dead_zone(longint'(z0) - longint'(ms), band);
    s = sat(longint'(z1) - longint'(qm(beta0, e)));
    s = sat(longint'(s) + longint'(qm(qm(b0, wt), dr)));
    z0 = sat(longint'(z0) + longint'(qm(t, s)));
    hb = qm(t, beta1);
    z1 = sat(longint'(z1) - longint'(qm(hb, e)));
    zl = qm(qm(lim, wt), sat(b0 + 65536));
    if (z1 > zl) z1 = int'(zl);
    if (z1 < -zl) z1 = int'(-zl);
    if (safe) z1 = 0;
    e1 = dead_zone(longint'(tg) - longint'(z0), band);
    u = qm(kp, e1);
    if (b0 != 0 && !safe) begin
      comp = sat((longint'(z1) * 65536) / b0);
      if ((e1 < 0 ? -longint'(e1) : longint'(e1)) > band) hold_comp = comp;
      u = sat(u - qm(wt, hold_comp));
    end
    if (u > lim) u = lim;
    if (u < -lim) u = -lim;
    r.drive = sat(u);
    r.est = z0;
    r.disturb = z1;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none in calm stretches
  function automatic int pick_gap();
    int k;
    if (calm) return 0;
    k = $urandom_range(99);
    if (k < 45) return 0;
    if (k < 93) return $urandom_range(3, 1);
    return $urandom_range(80, 10);
  endfunction

  function automatic int near_value(int c, int span);
    return sat(longint'(c) + longint'($urandom_range(2 * span)) - span);
  endfunction

  task automatic send_sample(int tg, int ms, int dr, logic [15:0] ts);
    int gap;
    in_tdata <= {ts, dr, ms, tg};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(control_step(tg, ms, dr, ts));
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write one register once the controller has drained
  task automatic set_reg(logic [2:0] idx, logic [31:0] v);
    in_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (8) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_KP:   kp = v[30:0];
      REG_B0:   b0 = v[30:0];
      REG_W:    wt = v[30:0];
      REG_DZ:   band = v[30:0];
      REG_LIM:  lim = v[30:0];
      REG_SAFE: safe = v[0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] k, logic [31:0] b, logic [31:0] w,
                         logic [31:0] d, logic [31:0] l, logic [31:0] sm);
    set_reg(REG_KP, k);
    set_reg(REG_B0, b);
    set_reg(REG_W, w);
    set_reg(REG_DZ, d);
    set_reg(REG_LIM, l);
    set_reg(REG_SAFE, sm);
  endtask

  // Field extremes, zero and full periods, safe mode and zero model gain
  task automatic test_directed();
    send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd0);
    send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF);
    send_sample(0, 0, 0, 16'd1);
    set_all(32'hFFFF_FFFF, 32'd65536, 32'd131072, 32'd0, 32'd100 << 16, 32'd0);
    send_sample(32'sd5 << 16, 32'sd1 << 16, 32'sd2 << 16, 16'd655);
    send_sample(-(32'sd5 << 16), 32'sd3 << 16, -(32'sd2 << 16), 16'd65);
    send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 16'd0);
    send_sample(32'sd1, 32'sd1, 32'sd1, 16'd6553);
    set_reg(REG_SAFE, 32'hFFFF_FFFF);
    send_sample(32'sd9 << 16, -(32'sd4 << 16), 32'sd1 << 16, 16'd655);
    send_sample(-(32'sd9 << 16), 32'sd4 << 16, 0, 16'd100);
    set_reg(REG_SAFE, 32'd0);
    set_reg(REG_B0, 32'd0);
    send_sample(32'sd7 << 16, -(32'sd7 << 16), 32'sd3 << 16, 16'd1000);
    send_sample(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'd2);
    // Unmapped index must leave everything alone
    set_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_sample(32'sd2 << 16, 32'sd1 << 16, 0, 16'd300);
    set_all(32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0);
    send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF);
    send_sample(32'sh8000_0000, 0, 32'sh8000_0000, 16'd0);
  endtask

  // Tracking sequences around the estimate, with some full-range noise
  task automatic test_random_phase(int count);
    int tg, ms, dr, span;
    logic [15:0] ts;
    calm = ($urandom_range(3) == 0);
    for (int i = 0; i < count; i++) begin
      span = ($urandom_range(3) == 0) ? 32'sd200 << 16 : 32'sd8 << 16;
      if ($urandom_range(9) < 2) begin
        tg = $urandom;
        ms = $urandom;
        dr = $urandom;
        ts = 16'($urandom);
      end else begin
        tg = near_value(z0, span);
        ms = near_value(z0, span);
        dr = near_value(0, span);
        ts = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(6600, 0));
      end
      send_sample(tg, ms, dr, ts);
      if (i % 60 == 59) calm = ($urandom_range(3) == 0);
    end
    calm = 1'b0;
  endtask

  task automatic test_settings();
    set_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    test_random_phase(200);
    set_all(0, 0, 0, 0, 0, 0);
    test_random_phase(200);
    set_all(32'd2 << 16, 32'd35 << 16, 32'd65536, 32'd1 << 16, 32'd400 << 16, 0);
    test_random_phase(300);
    for (int p = 0; p < 5; p++) begin
      set_all($urandom_range(3) == 0 ? $urandom : $urandom_range(8 << 16),
              $urandom_range(4) == 0 ? 0 : ($urandom_range(3) == 0 ? $urandom
                                           : $urandom_range(60 << 16)),
              $urandom_range(3) == 0 ? $urandom : $urandom_range(3 << 16),
              $urandom_range(3) == 0 ? $urandom : $urandom_range(4 << 16),
              $urandom_range(3) == 0 ? $urandom : $urandom_range(1000 << 16),
              32'($urandom_range(3) == 0));
      test_random_phase(240);
    end
  endtask

  // Result stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (calm || $urandom_range(99) < 75) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(80, 10) : $urandom_range(2);
    end
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin
    ctrl_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result item %h", out_tdata);
        failed = 1'b1;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tdata[31:0] !== exp_r.drive) begin
          $error("drive_out expected %0d actual %0d", exp_r.drive, $signed(out_tdata[31:0]));
          failed = 1'b1;
        end
        if (out_tdata[63:32] !== exp_r.est) begin
          $error("est_value expected %0d actual %0d", exp_r.est, $signed(out_tdata[63:32]));
          failed = 1'b1;
        end
        if (out_tdata[95:64] !== exp_r.disturb) begin
          $error("est_disturbance expected %0d actual %0d", exp_r.disturb,
                 $signed(out_tdata[95:64]));
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    failed = 1'b0;
    calm = 1'b0;
    cycles = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    kp = KP_RST;
    b0 = B0_RST;
    wt = W_RST;
    band = DZ_RST;
    lim = LIM_RST;
    safe = 1'b0;
    z0 = 0;
    z1 = 0;
    hold_comp = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_settings();
    in_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
